### src/skct_pkg.sv
// shared types, constants and codes of the sorted key count table
package skct_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int COUNT_WIDTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int USED_W      = IDX_W + 1;
	localparam int KEY_W       = 24;
	localparam int POS_W       = 10;
	localparam int OUT_CNT_W   = 32;
	localparam int TOTAL_W     = 32;
	localparam int USED_OUT_W  = 11;
	localparam int CMD_W       = 2;
	localparam int S_TDATA_W   = 72;
	localparam int M_TDATA_W   = 112;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOTAL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]       key;
		logic [COUNT_WIDTH-1:0] count;
	} entry_t;

	typedef struct packed {
		logic [POS_W-1:0]     idx;
		logic                 existed;
		logic                 full;
		logic [KEY_W-1:0]     key;
		logic [OUT_CNT_W-1:0] count;
	} res_t;

	typedef struct packed {
		logic shift;
		logic done;
	} head_ctl_t;

endpackage

### src/skct_cell.sv
// one ring cell: holds one table entry and hands it on while the ring turns
module skct_cell (
	input  logic            clk,
	input  logic            shift,
	input  skct_pkg::entry_t d,
	output skct_pkg::entry_t q
);
	import skct_pkg::*;

	entry_t ent_q;

	// payload only, no reset: entries above the fill count are never observed
	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

### src/skct_head.sv
// head unit: walks the turning ring, matches, inserts and reads entries
module skct_head (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          op_read,
	input  logic [skct_pkg::KEY_W-1:0]    key,
	input  logic [31:0]                   cnt,
	input  logic [skct_pkg::POS_W-1:0]    ridx,
	input  skct_pkg::entry_t              head_in,
	output skct_pkg::entry_t              tail_out,
	output skct_pkg::head_ctl_t           ctl,
	output skct_pkg::res_t                res,
	output logic [skct_pkg::USED_W-1:0]   used
);
	import skct_pkg::*;

	localparam int WIDE_W = (COUNT_WIDTH > 32 ? COUNT_WIDTH : 32) + 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	localparam logic [1:0] MD_SEARCH = 2'd0;
	localparam logic [1:0] MD_SHIFT  = 2'd1;
	localparam logic [1:0] MD_DONE   = 2'd2;

	logic                   active_q;
	logic                   done_q;
	logic [IDX_W-1:0]       step_q;
	logic [1:0]             mode_q;
	logic [USED_W-1:0]      used_q;
	logic                   ins_q;
	logic                   op_read_q;
	logic [KEY_W-1:0]       key_q;
	logic [COUNT_WIDTH-1:0] cnt_sat_q;
	logic [POS_W-1:0]       ridx_q;
	entry_t                 carry_q;
	res_t                   res_q;

	logic [WIDE_W-1:0]      cnt_wide;
	logic [COUNT_WIDTH-1:0] cnt_sat;
	logic [WIDE_W-1:0]      sum;
	logic [COUNT_WIDTH-1:0] sum_sat;
	logic                   valid_e;
	logic                   is_full;
	logic                   last_step;
	entry_t                 new_ent;
	entry_t                 tail;
	entry_t                 carry_n;
	logic [1:0]             mode_n;
	logic                   ins_n;
	res_t                   res_n;

	// incoming count clamped to the count range
	assign cnt_wide = WIDE_W'(cnt);
	assign cnt_sat  = (cnt_wide > WIDE_W'(CNT_MAX)) ? CNT_MAX : cnt_wide[COUNT_WIDTH-1:0];

	// saturating accumulate; both operands are within range so the sum fits
	assign sum     = WIDE_W'(head_in.count) + WIDE_W'(cnt_sat_q);
	assign sum_sat = (sum > WIDE_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_WIDTH-1:0];

	assign valid_e   = {1'b0, step_q} < used_q;
	assign is_full   = used_q == USED_W'(TABLE_DEPTH);
	assign last_step = step_q == IDX_W'(TABLE_DEPTH - 1);
	assign new_ent   = '{key: key_q, count: cnt_sat_q};

	always_comb begin
		tail    = head_in;
		carry_n = carry_q;
		mode_n  = mode_q;
		ins_n   = ins_q;
		res_n   = res_q;
		if (op_read_q) begin
			if (valid_e && (32'(step_q) == 32'(ridx_q))) begin
				res_n.key   = head_in.key;
				res_n.count = OUT_CNT_W'(head_in.count);
			end
		end else begin
			case (mode_q)
				MD_SEARCH: begin
					if (!valid_e) begin
						// first free slot: append
						tail      = new_ent;
						ins_n     = 1'b1;
						res_n.idx = POS_W'(step_q);
						mode_n    = MD_DONE;
					end else if (head_in.key == key_q) begin
						tail.count    = sum_sat;
						res_n.existed = 1'b1;
						res_n.idx     = POS_W'(step_q);
						res_n.count   = OUT_CNT_W'(sum_sat);
						mode_n        = MD_DONE;
					end else if (head_in.key > key_q) begin
						if (is_full) begin
							res_n.full = 1'b1;
							mode_n     = MD_DONE;
						end else begin
							tail        = new_ent;
							carry_n     = head_in;
							ins_n       = 1'b1;
							res_n.idx   = POS_W'(step_q);
							res_n.count = OUT_CNT_W'(cnt_sat_q);
							mode_n      = MD_SHIFT;
						end
					end else if (last_step) begin
						// every slot holds a smaller key: table full
						res_n.full = 1'b1;
						mode_n     = MD_DONE;
					end
					if (!valid_e) begin
						res_n.count = OUT_CNT_W'(cnt_sat_q);
					end
				end
				MD_SHIFT: begin
					// displaced entries ripple up by one slot
					tail    = carry_q;
					carry_n = head_in;
					if (!valid_e) begin
						mode_n = MD_DONE;
					end
				end
				default: begin
					tail = head_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= '0;
			mode_q   <= MD_SEARCH;
			used_q   <= '0;
			ins_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
				mode_q   <= MD_SEARCH;
				ins_q    <= 1'b0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				mode_q <= mode_n;
				ins_q  <= ins_n;
				if (last_step) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
					if (ins_n) begin
						used_q <= used_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_read_q     <= op_read;
			key_q         <= key;
			cnt_sat_q     <= cnt_sat;
			ridx_q        <= ridx;
			res_q.idx     <= op_read ? ridx : '0;
			res_q.existed <= 1'b0;
			res_q.full    <= 1'b0;
			res_q.key     <= op_read ? '0 : key;
			res_q.count   <= '0;
		end else if (active_q) begin
			carry_q <= carry_n;
			res_q   <= res_n;
		end
	end

	assign tail_out  = tail;
	assign ctl.shift = active_q;
	assign ctl.done  = done_q;
	assign res       = res_q;
	assign used      = used_q;

endmodule

### src/sorted_key_count_table.sv
// top level of the sorted key count table: ring of entry cells, head unit, beat stages
//
// usage
//  - input beats arrive on s_axis_*; tuser carries the command (add entry, add file
//    total, read entry), tdata the key bytes, the count and the read index
//  - every input beat gives exactly one output beat on m_axis_*
//  - the table lives in a ring of TABLE_DEPTH cells; an add or a read turns the ring
//    once round while the head unit compares each entry passing by, accumulates
//    into a match or slips a new entry in and ripples the rest up
//  - add and read reach the result stage at the end of the ring turn, a file total
//    or an unused command straight from input; from there it moves to the output register
//  - one item at a time; the single head unit and the full ring turn set this
//  - s_axis_tready is high whenever no item is in flight, also while a finished beat
//    waits in the output register; a stalled receiver only holds the next result
//    in its result stage until the output register is free
//  - reset clears the fill count, the grand total and all control; cell contents
//    need no clearing since only entries below the fill count are ever looked at
//
module sorted_key_count_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// key_id, key_byte_one, key_byte_two, add_count, read_index, zero pad
	input  logic [skct_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// command
	input  logic [skct_pkg::CMD_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// entry_index, key_existed, table_full, out_id, out_byte_one, out_byte_two,
	// out_count, grand_total_out, entries_used, zero pad
	output logic [skct_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import skct_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]          state_q;
	logic                from_head_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                out_valid_q;
	res_t                out_res_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic [USED_OUT_W-1:0] out_used_q;

	logic                in_beat;
	logic                start;
	logic                hold_free;
	logic                load_out;
	logic [CMD_W-1:0]    cmd;
	logic [KEY_W-1:0]    in_key;
	logic [31:0]         in_cnt;
	logic [POS_W-1:0]    in_ridx;
	logic [TOTAL_W:0]    total_sum;

	entry_t              ring [TABLE_DEPTH];
	entry_t              tail;
	head_ctl_t           ctl;
	res_t                head_res;
	logic [USED_W-1:0]   used;

	// input beat fields
	assign cmd     = s_axis_tuser;
	assign in_key  = s_axis_tdata[23:0];
	assign in_cnt  = s_axis_tdata[55:24];
	assign in_ridx = s_axis_tdata[65:56];

	assign s_axis_tready = state_q == ST_IDLE;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign start         = in_beat && ((cmd == CMD_ADD) || (cmd == CMD_READ));
	assign hold_free     = !out_valid_q || m_axis_tready;
	// result stage moves into the output register
	assign load_out      = (state_q == ST_HOLD) && hold_free;

	// key bytes are packed id first in the low byte; the stored key puts id on top
	// so that numeric order is the lexicographic order of the three bytes
	logic [KEY_W-1:0] key_ord;
	assign key_ord = {in_key[7:0], in_key[15:8], in_key[23:16]};

	// the ring: every cell takes its upper neighbour, the top cell takes the head's output
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_top
			skct_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (tail),
				.q     (ring[i])
			);
		end else begin : g_mid
			skct_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (ring[i+1]),
				.q     (ring[i])
			);
		end
	end

	skct_head u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op_read  (cmd == CMD_READ),
		.key      (key_ord),
		.cnt      (in_cnt),
		.ridx     (in_ridx),
		.head_in  (ring[0]),
		.tail_out (tail),
		.ctl      (ctl),
		.res      (head_res),
		.used     (used)
	);

	// saturating grand total
	assign total_sum = {1'b0, total_q} + {1'b0, in_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			from_head_q <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						from_head_q <= start;
						state_q     <= start ? ST_PASS : ST_HOLD;
						if (cmd == CMD_TOTAL) begin
							total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
						end
					end
				end
				ST_PASS: begin
					if (ctl.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (hold_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_res_q   <= from_head_q ? head_res : '0;
			out_total_q <= total_q;
			out_used_q  <= USED_OUT_W'(used);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0,
				out_used_q,
				out_total_q,
				out_res_q.count,
				out_res_q.key[7:0],
				out_res_q.key[15:8],
				out_res_q.key[23:16],
				out_res_q.full,
				out_res_q.existed,
				out_res_q.idx};

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		used <= USED_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |-> (state_q == ST_PASS))
		else $error("ring pass ended outside a pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(used != $past(used)) |-> (ctl.done && (used == $past(used) + 1'b1)))
		else $error("fill count moved other than by one at a pass end");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_res_q.existed && out_res_q.full))
		else $error("result both matched and dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> !s_axis_tready)
		else $error("input taken while the ring turns");
`endif

endmodule
